// File: rtl/olist_pkg.sv
// Shared types and codes for the ordered byte list engine.
`default_nettype none
package olist_pkg;

    // Request kinds carried on i_kind.
    localparam logic [2:0] KIND_APPEND = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_REMOVE = 3'd2;
    localparam logic [2:0] KIND_FIND   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Status codes carried on o_status.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Fixed field widths.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 5;
    localparam int COUNT_W  = 6;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               append;
        logic               insert;
        logic               remove;
        logic [VALUE_W-1:0] value;
    } t_cell_cmd;

endpackage
`default_nettype wire

// File: rtl/olist_cell.sv
// One storage cell of the list chain: holds a byte, loads, shifts and compares it.
`default_nettype none
module olist_cell #(
    parameter int IDX  = 0,
    parameter int CMPW = 6
) (
    input  wire                       i_clk,
    input  wire olist_pkg::t_cell_cmd i_cmd,
    input  wire  [CMPW-1:0]           i_pos,
    input  wire  [CMPW-1:0]           i_len,
    input  wire  [olist_pkg::VALUE_W-1:0] i_prev,
    input  wire  [olist_pkg::VALUE_W-1:0] i_next,
    output logic [olist_pkg::VALUE_W-1:0] o_entry,
    output logic                      o_match
);
    import olist_pkg::*;

    localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               w_at_pos;
    logic               w_past_pos;
    logic               w_at_len;

    // Position of this cell relative to the request.
    assign w_at_pos   = (MY_IDX == i_pos);
    assign w_past_pos = (MY_IDX > i_pos);
    assign w_at_len   = (MY_IDX == i_len);

    // Next content: new byte, neighbor behind, neighbor ahead, or unchanged.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.append && w_at_len) begin
            n_entry = i_cmd.value;
        end else if (i_cmd.insert && w_at_pos) begin
            n_entry = i_cmd.value;
        end else if (i_cmd.insert && w_past_pos) begin
            n_entry = i_prev;
        end else if (i_cmd.remove && (w_at_pos || w_past_pos)) begin
            n_entry = i_next;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // A match counts only inside the valid part of the list.
    assign o_match = (r_entry == i_cmd.value) && (MY_IDX < i_len);

endmodule
`default_nettype wire

// File: rtl/ordered_byte_list_engine_top.sv
// Top level of the ordered byte list engine: request decode, cell chain, result stage.
// A result strobes on o_valid once the request has passed the r_a_* stage and the output registers.
// Throughput: one request per cycle while o_busy is low; every cell updates in parallel and the
// first-match encode for find sits in the second stage of the result pipeline.
// o_busy is high during reset and until the first clock edge after it; the receiver cannot stall.
// Reset (synchronous, active low) empties the list; stored bytes are not cleared.
`default_nettype none
module ordered_byte_list_engine_top #(
    parameter int CAPACITY = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    output logic                           o_busy,
    input  wire  [olist_pkg::KIND_W-1:0]   i_kind,
    input  wire  [olist_pkg::POS_W-1:0]    i_position,
    input  wire  [olist_pkg::VALUE_W-1:0]  i_value,
    output logic                           o_valid,
    output logic [olist_pkg::STATUS_W-1:0] o_status,
    output logic [olist_pkg::FIDX_W-1:0]   o_found_index,
    output logic [olist_pkg::COUNT_W-1:0]  o_count
);
    import olist_pkg::*;

    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (LW > POS_W) ? LW : POS_W;
    localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

    logic               r_busy;
    logic [LW-1:0]      r_length;
    logic [LW-1:0]      n_length;
    logic               w_accept;
    logic [CMPW-1:0]    w_len;
    logic [CMPW-1:0]    w_pos;
    logic               w_full;
    logic [STATUS_W-1:0] w_status;
    t_cell_cmd          w_cmd;

    logic [VALUE_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    // First pipeline stage.
    logic                r_a_valid;
    logic                r_a_find;
    logic [STATUS_W-1:0] r_a_status;
    logic [CMPW-1:0]     r_a_count;
    logic [CAPACITY-1:0] r_a_match;

    // Second stage helpers.
    logic                w_hit;
    logic [IW-1:0]       w_hit_idx;
    logic [CMPW-1:0]     w_hit_wide;

    assign w_accept = i_start && !r_busy;
    assign w_len    = CMPW'(r_length);
    assign w_pos    = CMPW'(i_position);
    assign w_full   = (w_len >= CAP_C);

    // Decode the request into a status, new length and cell command.
    always_comb begin
        w_status     = ST_OK;
        n_length     = r_length;
        w_cmd.append = 1'b0;
        w_cmd.insert = 1'b0;
        w_cmd.remove = 1'b0;
        w_cmd.value  = i_value;
        unique case (i_kind)
            KIND_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.append = w_accept;
                    n_length     = r_length + LW'(1);
                end
            end
            KIND_INSERT: begin
                if (w_pos > w_len) begin
                    w_status = ST_BADPOS;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.insert = w_accept;
                    n_length     = r_length + LW'(1);
                end
            end
            KIND_REMOVE: begin
                if (w_pos >= w_len) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_cmd.remove = w_accept;
                    n_length     = r_length - LW'(1);
                end
            end
            KIND_CLEAR: begin
                n_length = '0;
            end
            default: begin
                // Find and unused kinds leave the list as it is.
            end
        endcase
    end

    // The chain of cells; each takes from its neighbors when shifting.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_W-1:0] w_prev;
        logic [VALUE_W-1:0] w_next;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[k];
        end else begin : g_mid_next
            assign w_next = w_entry[k+1];
        end
        olist_cell #(
            .IDX  (k),
            .CMPW (CMPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_len   (w_len),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[k]),
            .o_match (w_match[k])
        );
    end

    // First matching cell of the registered match vector.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_a_match[i]) begin
                w_hit     = 1'b1;
                w_hit_idx = IW'(i);
            end
        end
    end
    assign w_hit_wide = CMPW'(w_hit_idx);

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_length  <= '0;
            r_a_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_a_valid <= w_accept;
            o_valid   <= r_a_valid;
            if (w_accept) begin
                r_length <= n_length;
            end
        end
    end

    // Payload of both result stages.
    always_ff @(posedge i_clk) begin
        r_a_find   <= (i_kind == KIND_FIND);
        r_a_status <= w_status;
        r_a_count  <= CMPW'(n_length);
        r_a_match  <= w_match;
        o_count    <= r_a_count[COUNT_W-1:0];
        if (r_a_find) begin
            o_status      <= w_hit ? ST_OK : ST_NOTFOUND;
            o_found_index <= w_hit ? w_hit_wide[FIDX_W-1:0] : '0;
        end else begin
            o_status      <= r_a_status;
            o_found_index <= '0;
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// File: rtl/olist_checker.sv
// Port-level checks for the ordered byte list engine, bound to the top level.
`default_nettype none
module olist_checker #(
    parameter int CAPACITY = 32
) (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_start,
    input wire                            o_busy,
    input wire [olist_pkg::KIND_W-1:0]    i_kind,
    input wire                            o_valid,
    input wire [olist_pkg::STATUS_W-1:0]  o_status,
    input wire [olist_pkg::FIDX_W-1:0]    o_found_index,
    input wire [olist_pkg::COUNT_W-1:0]   o_count
);
    import olist_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

    // Every accepted beat produces a result, through r_a_valid and then o_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("accepted beat gave no result");

    // No result appears without an accepted beat that passed through r_a_valid.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without accepted beat");

    // A failed find reports index zero.
    a_notfound_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOTFOUND) |-> (o_found_index == '0))
        else $error("not found with nonzero index");

    // A full report means the list holds exactly its capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == CAP_CNT))
        else $error("full status with wrong count");

    // A clear leaves an empty list.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == KIND_CLEAR) |=> ##1 (o_count == '0))
        else $error("clear did not empty the list");

endmodule

bind ordered_byte_list_engine_top olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);
`default_nettype wire
